// File: src/cosine_topk_vector_search_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cosine top-k vector search block
// Assertions compile in simulation and vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef COSINE_TOPK_VECTOR_SEARCH_MACROS_SVH
`define COSINE_TOPK_VECTOR_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define CTVS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CTVS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CTVS_ASSERT(lbl, clk, rst_n, prop)
`define CTVS_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: src/ctvs_pkg.sv
// ----------------------------------------------------------------------------
// ctvs_pkg
// Shared types and constants of the cosine top-k vector search block.
// ----------------------------------------------------------------------------
package ctvs_pkg;

    localparam int DIM_MAX_DEF     = 1024;
    localparam int TOPK_MAX_DEF    = 16;
    localparam int VECTORS_MAX_DEF = 65536;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] CFG_DIM_IN_USE   = 2'd0;
    localparam logic [1:0] CFG_TOP_K        = 2'd1;
    localparam logic [1:0] CFG_VECTOR_TOTAL = 2'd2;

    localparam logic [10:0] DIM_RESET   = 11'd1024;
    localparam logic [4:0]  TOPK_RESET  = 5'd16;
    localparam logic [16:0] VTOTAL_RESET = 17'h10000;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_DB    = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] value;
    } t_in_word;

    typedef struct packed {
        logic [15:0]        match_index;
        logic signed [15:0] match_score;
        logic               last_match;
    } t_out_word;

endpackage

// File: src/ctvs_fifo.sv
// ----------------------------------------------------------------------------
// ctvs_fifo
// Short register queue that carries finished vector sums to the scorer.
// ----------------------------------------------------------------------------
`include "cosine_topk_vector_search_macros.svh"

module ctvs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    `CTVS_NEVER(a_no_overflow, i_clk, i_rst_n, r_cnt > CNT_W'(DEPTH))
    `CTVS_ASSERT(a_count_track, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_cnt != '0))

endmodule

// File: src/ctvs_front.sv
// ----------------------------------------------------------------------------
// ctvs_front
// Takes words, keeps the query vector and accumulates dot product and norms
// for each database vector; hands finished sums to the scoring queue.
// ----------------------------------------------------------------------------
module ctvs_front #(
    parameter int DIM_MAX     = 1024,
    parameter int VECTORS_MAX = 65536
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_push,
    input  ctvs_pkg::t_in_word                          i_item,
    output logic                                        o_full,
    input  logic [$clog2(DIM_MAX+1)-1:0]                i_dim,
    input  logic [$clog2(VECTORS_MAX+1)-1:0]            i_total,
    output logic                                        o_job_push,
    output logic [1+16+3*(32+$clog2(DIM_MAX))-1:0]      o_job,
    input  logic                                        i_job_full
);
    import ctvs_pkg::*;

    localparam int DIM_CW = $clog2(DIM_MAX + 1);
    localparam int POS_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int ACC_W  = 32 + $clog2(DIM_MAX);
    localparam int VC_W   = $clog2(VECTORS_MAX + 1);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC} t_fstate;

    t_fstate                 r_state;
    logic signed [15:0]      r_mem [DIM_MAX];
    logic signed [15:0]      r_qdata;
    logic                    r_op;
    logic signed [15:0]      r_val;
    logic [POS_W-1:0]        r_idx;
    logic                    r_restart;
    logic signed [31:0]      r_pq, r_pv;
    logic [POS_W-1:0]        r_qfill, r_pos;
    logic signed [ACC_W-1:0] r_qn, r_dot, r_vn;
    logic [VC_W-1:0]         r_vcnt;
    logic                    accept;
    logic [POS_W-1:0]        qidx, pidx;
    logic [DIM_CW:0]         next_cnt;
    logic signed [ACC_W-1:0] dot_n, vn_n;
    logic                    total_hit;

    assign accept = i_push && (r_state == F_IDLE);
    assign o_full = (r_state != F_IDLE);

    // A shrunk dimension pulls both fill and position back into range.
    assign qidx = ({1'b0, DIM_CW'(r_qfill)} >= {1'b0, i_dim}) ? '0 : r_qfill;
    assign pidx = ({1'b0, DIM_CW'(r_pos)} >= {1'b0, i_dim}) ?
                  POS_W'(i_dim - 1'b1) : r_pos;

    assign next_cnt  = (DIM_CW + 1)'(r_idx) + 1'b1;
    assign dot_n     = r_dot + ACC_W'(r_pq);
    assign vn_n      = r_vn + ACC_W'(r_pv);
    assign total_hit = ((VC_W + 1)'(r_vcnt) + 1'b1) >= {1'b0, i_total};

    assign o_job_push = (r_state == F_ACC) && (r_op == OP_DB) &&
                        (next_cnt >= {1'b0, i_dim}) && !i_job_full;
    assign o_job      = {total_hit, 16'(r_vcnt), dot_n, vn_n, r_qn};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_item.op == OP_QUERY) begin
                r_mem[qidx] <= i_item.value;
            end else begin
                r_qdata <= r_mem[pidx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_qfill <= '0;
            r_pos   <= '0;
            r_qn    <= '0;
            r_dot   <= '0;
            r_vn    <= '0;
            r_vcnt  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_op      <= i_item.op;
                        r_val     <= i_item.value;
                        r_idx     <= (i_item.op == OP_QUERY) ? qidx : pidx;
                        r_restart <= (qidx == '0);
                        r_state   <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_pq    <= r_qdata * r_val;
                    r_pv    <= r_val * r_val;
                    r_state <= F_ACC;
                end
                F_ACC: begin
                    if (r_op == OP_QUERY) begin
                        r_qn    <= (r_restart ? '0 : r_qn) + ACC_W'(r_pv);
                        r_qfill <= (next_cnt >= {1'b0, i_dim}) ? '0 : POS_W'(next_cnt);
                        r_state <= F_IDLE;
                    end else if (next_cnt < {1'b0, i_dim}) begin
                        r_dot   <= dot_n;
                        r_vn    <= vn_n;
                        r_pos   <= POS_W'(next_cnt);
                        r_state <= F_IDLE;
                    end else if (!i_job_full) begin
                        r_dot   <= '0;
                        r_vn    <= '0;
                        r_pos   <= '0;
                        r_vcnt  <= total_hit ? '0 : r_vcnt + 1'b1;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// File: src/ctvs_back.sv
// ----------------------------------------------------------------------------
// ctvs_back
// Scores each finished vector with a shift-add multiplier and a bit-serial
// root search, keeps the sorted best list and emits it at the end of a search.
// ----------------------------------------------------------------------------
`include "cosine_topk_vector_search_macros.svh"

module ctvs_back #(
    parameter int DIM_MAX  = 1024,
    parameter int TOPK_MAX = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [1+16+3*(32+$clog2(DIM_MAX))-1:0]   i_job,
    input  logic                                     i_job_empty,
    output logic                                     o_job_pop,
    input  logic [$clog2(TOPK_MAX+1)-1:0]            i_k,
    output logic                                     o_empty,
    input  logic                                     i_pop,
    output ctvs_pkg::t_out_word                      o_result
);
    import ctvs_pkg::*;

    localparam int ACC_W  = 32 + $clog2(DIM_MAX);
    localparam int MAG_W  = ACC_W - 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SW     = PROD_W + 34;
    localparam int MCNT_W = $clog2(MAG_W);
    localparam int FILL_W = $clog2(TOPK_MAX + 1);

    typedef enum logic [2:0] {
        B_IDLE, B_MUL, B_SRCH_A, B_SRCH_B, B_INSERT, B_EMIT
    } t_bstate;

    t_bstate                 r_state;
    logic                    r_last, r_neg, r_sel;
    logic [15:0]             r_idx;
    logic [MAG_W-1:0]        r_mag, r_mb;
    logic [PROD_W-1:0]       r_ma, r_macc, r_p;
    logic [MCNT_W-1:0]       r_mcnt;
    logic [SW-1:0]           r_t, r_s2, r_u, r_pb, r_cand;
    logic [3:0]              r_bit;
    logic [15:0]             r_s;
    logic signed [15:0]      r_best_score [TOPK_MAX];
    logic [15:0]             r_best_idx   [TOPK_MAX];
    logic [FILL_W-1:0]       r_fill;
    logic                    r_out_valid;
    t_out_word               r_out;

    logic                    j_last;
    logic [15:0]             j_idx;
    logic signed [ACC_W-1:0] j_dot, j_vn, j_qn, j_abs;
    logic [PROD_W-1:0]       macc_next;
    logic [SW-1:0]           u_set;
    logic signed [15:0]      score;
    logic [FILL_W-1:0]       fill_c, pos;
    logic [TOPK_MAX-1:0]     ge_vec;
    logic                    load_out;

    assign {j_last, j_idx, j_dot, j_vn, j_qn} = i_job;
    assign j_abs     = (j_dot < 0) ? -j_dot : j_dot;
    assign o_job_pop = (r_state == B_IDLE) && !i_job_empty;
    assign macc_next = r_mb[0] ? r_macc + r_ma : r_macc;
    assign u_set     = r_u + (r_pb << 1);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;
    assign load_out  = (r_state == B_EMIT) && (r_fill != '0) && (!r_out_valid || i_pop);

    // Root search result clamped to the Q1.15 range with the sign of the dot product.
    always_comb begin
        if (r_neg) begin
            score = r_s[15] ? 16'sh8000 : -$signed(r_s);
        end else begin
            score = r_s[15] ? 16'sh7fff : $signed(r_s);
        end
    end

    // The list is sorted, so entries at or above the new score form a prefix.
    always_comb begin
        fill_c = (r_fill > i_k) ? i_k : r_fill;
        for (int i = 0; i < TOPK_MAX; i++) begin
            ge_vec[i] = (FILL_W'(i) < fill_c) && (r_best_score[i] >= score);
        end
        pos = FILL_W'($countones(ge_vec));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && !load_out) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_last <= j_last;
                        r_idx  <= j_idx;
                        r_neg  <= (j_dot < 0);
                        r_mag  <= MAG_W'(j_abs);
                        r_s    <= '0;
                        if (j_qn == '0 || j_vn == '0) begin
                            r_state <= B_INSERT;
                        end else begin
                            r_ma    <= PROD_W'(j_qn[MAG_W-1:0]);
                            r_mb    <= j_vn[MAG_W-1:0];
                            r_macc  <= '0;
                            r_mcnt  <= '0;
                            r_sel   <= 1'b0;
                            r_state <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    if (r_mcnt == MCNT_W'(MAG_W - 1)) begin
                        r_mcnt <= '0;
                        r_macc <= '0;
                        if (!r_sel) begin
                            r_p   <= macc_next;
                            r_ma  <= PROD_W'(r_mag);
                            r_mb  <= r_mag;
                            r_sel <= 1'b1;
                        end else begin
                            r_t     <= SW'(macc_next) << 30;
                            r_pb    <= SW'(r_p) << 30;
                            r_s2    <= '0;
                            r_u     <= '0;
                            r_bit   <= 4'd15;
                            r_state <= B_SRCH_A;
                        end
                    end else begin
                        r_macc <= macc_next;
                        r_ma   <= r_ma << 1;
                        r_mb   <= r_mb >> 1;
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
                B_SRCH_A: begin
                    // (s + 2^b)^2 * P = s^2*P + s*P*2^(b+1) + P*2^(2b)
                    r_cand  <= r_s2 + r_u + r_pb;
                    r_state <= B_SRCH_B;
                end
                B_SRCH_B: begin
                    if (r_cand <= r_t) begin
                        r_s[r_bit] <= 1'b1;
                        r_s2       <= r_cand;
                        r_u        <= u_set >> 1;
                    end else begin
                        r_u <= r_u >> 1;
                    end
                    r_pb <= r_pb >> 2;
                    if (r_bit == '0) begin
                        r_state <= B_INSERT;
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= B_SRCH_A;
                    end
                end
                B_INSERT: begin
                    if ((FILL_W + 1)'(pos) < (FILL_W + 1)'(i_k)) begin
                        for (int i = 0; i < TOPK_MAX; i++) begin
                            if (FILL_W'(i) == pos) begin
                                r_best_score[i] <= score;
                                r_best_idx[i]   <= r_idx;
                            end else if (FILL_W'(i) > pos && i > 0) begin
                                r_best_score[i] <= r_best_score[(i > 0) ? i - 1 : 0];
                                r_best_idx[i]   <= r_best_idx[(i > 0) ? i - 1 : 0];
                            end
                        end
                        r_fill <= (fill_c < i_k) ? fill_c + 1'b1 : i_k;
                    end else begin
                        r_fill <= fill_c;
                    end
                    r_state <= r_last ? B_EMIT : B_IDLE;
                end
                B_EMIT: begin
                    if (r_fill == '0) begin
                        r_state <= B_IDLE;
                    end else if (load_out) begin
                        r_out_valid       <= 1'b1;
                        r_out.match_index <= r_best_idx[0];
                        r_out.match_score <= r_best_score[0];
                        r_out.last_match  <= (r_fill == FILL_W'(1));
                        for (int i = 0; i + 1 < TOPK_MAX; i++) begin
                            r_best_score[i] <= r_best_score[i + 1];
                            r_best_idx[i]   <= r_best_idx[i + 1];
                        end
                        r_fill <= r_fill - 1'b1;
                        if (r_fill == FILL_W'(1)) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `CTVS_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > FILL_W'(TOPK_MAX))
    `CTVS_ASSERT(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == B_EMIT))

endmodule

// File: src/cosine_topk_vector_search.sv
// Each input word passes through the front end in order (query memory read, multiply,
// accumulate); full stays high until the word is done, so no new word is taken before then.
// Scoring a finished vector in the back end takes two serial shift-add multiplies and a 16-bit
// root search; results leave one per cycle while the reader keeps popping them.
// Reset is synchronous, active low: it clears all control state and restores the
// register defaults; the query memory holds nothing valid until a query is loaded.
// ----------------------------------------------------------------------------
// cosine_topk_vector_search
// Brute-force top-k cosine similarity search over a stream of vectors.
// ----------------------------------------------------------------------------
module cosine_topk_vector_search #(
    parameter int DIM_MAX     = ctvs_pkg::DIM_MAX_DEF,
    parameter int TOPK_MAX    = ctvs_pkg::TOPK_MAX_DEF,
    parameter int VECTORS_MAX = ctvs_pkg::VECTORS_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  ctvs_pkg::t_in_word            i_item,
    output logic                          empty,
    input  logic                          pop,
    output ctvs_pkg::t_out_word           o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctvs_pkg::ADDR_W-1:0]   paddr,
    input  logic [ctvs_pkg::DATA_W-1:0]   pwdata,
    output logic [ctvs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import ctvs_pkg::*;

    localparam int DIM_CW = $clog2(DIM_MAX + 1);
    localparam int K_W    = $clog2(TOPK_MAX + 1);
    localparam int VC_W   = $clog2(VECTORS_MAX + 1);
    localparam int JOB_W  = 1 + 16 + 3 * (32 + $clog2(DIM_MAX));

    logic [10:0]       r_dim;
    logic [4:0]        r_topk;
    logic [16:0]       r_vtot;
    logic [DIM_CW-1:0] dim_eff;
    logic [K_W-1:0]    k_eff;
    logic [VC_W-1:0]   total_eff;
    logic              cfg_wr;
    logic              job_push, job_full, job_pop, job_empty;
    logic [JOB_W-1:0]  job_in, job_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim  <= DIM_RESET;
            r_topk <= TOPK_RESET;
            r_vtot <= VTOTAL_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_DIM_IN_USE:   r_dim  <= pwdata[10:0];
                CFG_TOP_K:        r_topk <= pwdata[4:0];
                CFG_VECTOR_TOTAL: r_vtot <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_DIM_IN_USE:   prdata = DATA_W'(r_dim);
            CFG_TOP_K:        prdata = DATA_W'(r_topk);
            CFG_VECTOR_TOTAL: prdata = DATA_W'(r_vtot);
            default:          prdata = '0;
        endcase
    end

    assign dim_eff   = (r_dim == '0) ? DIM_CW'(1) :
                       (32'(r_dim) > 32'(DIM_MAX)) ? DIM_CW'(DIM_MAX) : DIM_CW'(r_dim);
    assign k_eff     = (32'(r_topk) > 32'(TOPK_MAX)) ? K_W'(TOPK_MAX) : K_W'(r_topk);
    assign total_eff = (r_vtot == '0) ? VC_W'(1) :
                       (32'(r_vtot) > 32'(VECTORS_MAX)) ? VC_W'(VECTORS_MAX) : VC_W'(r_vtot);

    ctvs_front #(
        .DIM_MAX     (DIM_MAX),
        .VECTORS_MAX (VECTORS_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_dim      (dim_eff),
        .i_total    (total_eff),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    ctvs_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    ctvs_back #(
        .DIM_MAX  (DIM_MAX),
        .TOPK_MAX (TOPK_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_k         (k_eff),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
